FILE: hdl/prp_pkg.sv
package prp_pkg;

  localparam int MAX_ROW_WIDTH = 4096;
  localparam int CNT_W         = $clog2(MAX_ROW_WIDTH);
  localparam int WID_W         = 13;
  localparam int CMP_W         = (CNT_W + 1 > WID_W) ? CNT_W + 1 : WID_W;
  localparam int MODE_W        = 2;
  localparam int WORD_W        = 32;
  localparam int BYTE_W        = 8;
  localparam int PAD_W         = 2;
  localparam int IDX_W         = 3;

  localparam logic [MODE_W-1:0] MODE_GREY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BINARY = 2'd1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one classified pixel waiting for the serializer
  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic              row_end;
    logic [PAD_W-1:0]  pads;
  } prp_item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } prp_q_stat_t;

endpackage

FILE: hdl/prp_front.sv
module prp_front import prp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [WORD_W-1:0] in_pixel_word,
  input  logic              q_full,
  input  logic [MODE_W-1:0] format_mode,
  input  logic [WID_W-1:0]  row_width,
  output logic              in_stall,
  output logic              push,
  output prp_item_t         item
);

  logic [CNT_W-1:0] col_r;
  logic [CNT_W-1:0] col_nxt;
  logic [CMP_W-1:0] w_eff;
  logic [CMP_W-1:0] col_plus;
  logic [BYTE_W-1:0] grey_b;
  logic [BYTE_W-1:0] bin_b;
  logic             row_end;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    if (row_width == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(row_width) > CMP_W'(MAX_ROW_WIDTH)) begin
      w_eff = CMP_W'(MAX_ROW_WIDTH);
    end else begin
      w_eff = CMP_W'(row_width);
    end
  end

  assign col_plus = CMP_W'(col_r) + CMP_W'(1);
  assign row_end  = (col_plus >= w_eff);

  // grey: 24.8 fixed point, integer part saturated
  assign grey_b = (|in_pixel_word[31:16]) ? 8'hff : in_pixel_word[15:8];
  assign bin_b  = 8'(8'd0 - in_pixel_word[7:0]);

  always_comb begin
    item.row_end = row_end;
    item.pads    = row_end ? w_eff[PAD_W-1:0] : '0;
    unique case (format_mode)
      MODE_GREY: begin
        item.b0 = grey_b;
        item.b1 = grey_b;
        item.b2 = grey_b;
      end
      MODE_BINARY: begin
        item.b0 = bin_b;
        item.b1 = bin_b;
        item.b2 = bin_b;
      end
      default: begin
        item.b0 = in_pixel_word[23:16];
        item.b1 = in_pixel_word[15:8];
        item.b2 = in_pixel_word[7:0];
      end
    endcase
  end

  assign col_nxt = row_end ? '0 : col_plus[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (push) begin
      col_r <= col_nxt;
    end
  end

endmodule

FILE: hdl/prp_queue.sv
module prp_queue import prp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  prp_item_t   push_item,
  input  logic        pop,
  output prp_item_t   head,
  output prp_q_stat_t stat
);

  prp_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign stat.count = cnt_r;
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/prp_back.sv
module prp_back import prp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  prp_item_t         head,
  input  logic              q_empty,
  input  logic              out_stall,
  output logic              pop,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte_value,
  output logic              out_is_padding,
  output logic              out_row_done,
  output logic              out_last_of_run
);

  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;
  logic              pad_r;
  logic              done_r;
  logic              last_r;
  logic              load;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_pad;
  logic              cur_final;

  assign load = !q_empty && (!valid_r || !out_stall);
  assign pop  = load && cur_final;

  always_comb begin
    cur_pad = (idx_r > IDX_W'(2));
    unique case (idx_r)
      3'd0:    cur_byte = head.b0;
      3'd1:    cur_byte = head.b1;
      3'd2:    cur_byte = head.b2;
      default: cur_byte = '0;
    endcase
  end

  // last color byte ends the run when there is no padding, else the last pad
  assign cur_final = cur_pad ? (idx_r == IDX_W'(2) + IDX_W'(head.pads))
                             : (idx_r == IDX_W'(2) && head.pads == '0);
  assign idx_nxt   = cur_final ? '0 : idx_r + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else if (load) begin
      idx_r   <= idx_nxt;
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      pad_r  <= cur_pad;
      done_r <= cur_final && head.row_end;
      last_r <= cur_final;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte_value  = byte_r;
  assign out_is_padding  = pad_r;
  assign out_row_done    = done_r;
  assign out_last_of_run = last_r;

endmodule

FILE: hdl/pixel_row_packer_rgb24_padded_unit.sv
// channel | direction | handshake           | payload
// in      | in        | in_valid / in_stall | in_pixel_word[31:0]
// out     | out       | out_valid/out_stall | byte_value, is_padding, row_done, last_of_run
// cfg     | in        | cfg_valid/cfg_ready | cfg_index[0], cfg_data[12:0]
//
// a pixel gives 3 color bytes, plus (width mod 4) pad bytes at a row end;
// the back end emits one byte per cycle unless out_stall is high or the queue is empty.
// an item passes the queue, then the output register, before its first byte is out.
// rst_n is synchronous: mode grey, width 1, column 0, queue empty.
// in_stall rises only when the 4-entry queue is full; out_stall freezes a
// valid output register and the serializer while the front keeps filling the queue.
module pixel_row_packer_rgb24_padded_unit import prp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_W-1:0]    in_pixel_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte_value,
  output logic                 out_is_padding,
  output logic                 out_row_done,
  output logic                 out_last_of_run,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WID_W-1:0]     cfg_data
);

  logic [MODE_W-1:0] format_mode_r;
  logic [WID_W-1:0]  row_width_r;
  logic              push;
  logic              pop;
  prp_item_t         f_item;
  prp_item_t         q_head;
  prp_q_stat_t       q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_mode_r <= MODE_GREY;
      row_width_r   <= WID_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FORMAT_MODE: format_mode_r <= cfg_data[MODE_W-1:0];
        REG_ROW_WIDTH:   row_width_r   <= cfg_data;
        default:         ;
      endcase
    end
  end

  prp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_pixel_word (in_pixel_word),
    .q_full        (q_stat.full),
    .format_mode   (format_mode_r),
    .row_width     (row_width_r),
    .in_stall      (in_stall),
    .push          (push),
    .item          (f_item)
  );

  prp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (f_item),
    .pop       (pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  prp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .q_empty         (q_stat.empty),
    .out_stall       (out_stall),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_byte_value  (out_byte_value),
    .out_is_padding  (out_is_padding),
    .out_row_done    (out_row_done),
    .out_last_of_run (out_last_of_run)
  );

`ifndef SYNTH
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_padding |-> out_byte_value == '0 && !$isunknown(out_row_done))
    else $error("pad byte not zero");

  a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_done |-> out_last_of_run)
    else $error("row end not on last byte of item");

  a_pad_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run ##1 out_valid && out_is_padding
    |-> !$past(out_row_done))
    else $error("padding after row end");
`endif

endmodule
